// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the clique cover block. Every macro samples on
// the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every sampled edge.
`define GCC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GCC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GCC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gcc_pkg.sv =====
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared constants, word types and memory port types of the greedy clique
// cover block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

    // Sizes
    localparam int MAX_VERTICES = 1024;
    localparam int VTX_W        = 10;
    localparam int CLQ_W        = 11;
    localparam int POS_W        = 10;
    localparam int CLQ_SLOTS    = 1025;
    localparam int CLQ_LIMIT    = 1024;
    localparam int CLQ_AW       = $clog2(CLQ_SLOTS);
    localparam int LBL_AW       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CLR_LEN      = (MAX_VERTICES > CLQ_SLOTS) ? MAX_VERTICES : CLQ_SLOTS;
    localparam int CLR_W        = $clog2(CLR_LEN + 1);

    localparam logic [CLQ_W-1:0] TAG_NONE = '1;
    localparam logic [CLQ_W-1:0] SIZE_MAX = '1;
    localparam logic [POS_W-1:0] POS_MAX  = '1;

    // Request codes
    localparam logic REQ_NEIGHBOR = 1'b0;
    localparam logic REQ_START    = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [VTX_W-1:0] vertex;
        logic [VTX_W-1:0] neighbor;
        logic             has_neighbor;
        logic             last_neighbor;
    } in_word_t;

    typedef struct packed {
        logic [VTX_W-1:0] placed_vertex;
        logic [CLQ_W-1:0] clique;
        logic [POS_W-1:0] position;
        logic [CLQ_W-1:0] cliques_used;
    } out_word_t;

    // Per-clique memory entry
    typedef struct packed {
        logic [CLQ_W-1:0] size;
        logic [CLQ_W-1:0] owner;
        logic [CLQ_W-1:0] count;
    } clq_entry_t;

    typedef struct packed {
        logic              en_size;
        logic              en_owner;
        logic              en_count;
        logic [CLQ_AW-1:0] addr;
        clq_entry_t        data;
    } clq_wr_t;

    typedef struct packed {
        logic              en;
        logic [CLQ_AW-1:0] addr;
    } clq_rd_t;

    typedef struct packed {
        logic              en;
        logic [LBL_AW-1:0] addr;
        logic [CLQ_W-1:0]  data;
    } lbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [LBL_AW-1:0] addr;
    } lbl_rd_t;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_CLQ,
        S_UPD,
        S_FIN,
        S_PUT
    } gcc_state_t;

endpackage

`default_nettype wire

// ===== rtl/gcc_label_mem.sv =====
// ----------------------------------------------------------------------------
// gcc_label_mem
// Vertex label memory: clique number of each vertex, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_label_mem (
    input  logic                      clk,
    input  gcc_pkg::lbl_rd_t          rd,
    output logic [gcc_pkg::CLQ_W-1:0] rd_data,
    input  gcc_pkg::lbl_wr_t          wr
);
    import gcc_pkg::*;

    logic [CLQ_W-1:0] mem [MAX_VERTICES];
    logic [CLQ_W-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gcc_clique_mem.sv =====
// ----------------------------------------------------------------------------
// gcc_clique_mem
// Per-clique memory: size, scratch owner tag and scratch count in one word,
// with a write enable for each field and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_clique_mem (
    input  logic                clk,
    input  gcc_pkg::clq_rd_t    rd,
    output gcc_pkg::clq_entry_t rd_data,
    input  gcc_pkg::clq_wr_t    wr
);
    import gcc_pkg::*;

    clq_entry_t mem [CLQ_SLOTS];
    clq_entry_t rd_data_reg;

    // Field-masked write, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en_size)
        begin
            mem[wr.addr].size <= wr.data.size;
        end
        if (wr.en_owner)
        begin
            mem[wr.addr].owner <= wr.data.owner;
        end
        if (wr.en_count)
        begin
            mem[wr.addr].count <= wr.data.count;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/greedy_clique_cover_top.sv =====
// ----------------------------------------------------------------------------
// greedy_clique_cover_top
// Greedy clique cover: from a stream of neighbor words, places each vertex into
// the lowest clique it fully touches, else a new one below the limit, else clique 0.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one word per neighbor of the
//    vertex being placed; last_neighbor marks its final word. A word with
//    req_type = start begins a new pass and clears labels and sizes.
//  - Output channel (out_valid/out_ready/out_data): one word per placed
//    vertex with its clique, its position in that clique and cliques used.
//  - cfg_we/cfg_wdata write max_cliques (reset value 1024); write only idle.
//  - A neighbor word takes a label read, then a read-modify-write of the
//    clique memory, which has a single read port; the next word can be taken
//    in S_UPD. The final word holds the input through S_CLQ, S_UPD, S_FIN
//    and S_PUT; its result is registered once the output register is free.
//  - After reset, after a start word and after every 2047 placed vertices
//    (scratch tag wrap; then only owner tags) a sweep clears the memories;
//    in_ready stays low during it.
//  - A stalled output register holds its word; the block keeps taking
//    neighbor words and waits only when the next result is due.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module greedy_clique_cover_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  gcc_pkg::in_word_t         in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output gcc_pkg::out_word_t        out_data,
    input  logic                      cfg_we,
    input  logic [gcc_pkg::CLQ_W-1:0] cfg_wdata
);
    import gcc_pkg::*;

    gcc_state_t        state_reg,       state_next;
    logic [CLQ_W-1:0]  max_cliques_reg;
    logic [CLQ_W-1:0]  open_reg,        open_next;
    logic [CLQ_W-1:0]  best_reg,        best_next;
    logic [CLQ_W-1:0]  ord_reg,         ord_next;
    logic [CLR_W-1:0]  clr_cnt_reg,     clr_cnt_next;
    logic              clr_full_reg,    clr_full_next;
    logic [VTX_W-1:0]  vtx_reg,         vtx_next;
    logic              last_reg,        last_next;
    logic              nb_ok_reg,       nb_ok_next;
    logic [CLQ_W-1:0]  q_reg,           q_next;
    logic              q_ok_reg,        q_ok_next;
    logic [CLQ_W-1:0]  color_reg,       color_next;
    logic              out_valid_reg,   out_valid_next;
    out_word_t         out_data_reg,    out_data_next;

    logic              accept;
    logic              put_go;
    logic [CLQ_W-1:0]  limit_c;
    logic [CLQ_W-1:0]  cnt_base_c;
    logic [CLQ_W-1:0]  cnt_new_c;
    logic [CLQ_W-1:0]  size_c;
    logic [CLQ_W-1:0]  ord_inc_c;

    lbl_rd_t           lbl_rd;
    lbl_wr_t           lbl_wr;
    logic [CLQ_W-1:0]  lbl_rd_data;
    clq_rd_t           clq_rd;
    clq_wr_t           clq_wr;
    clq_entry_t        clq_rd_data;

    // Memories
    gcc_label_mem u_label_mem (
        .clk     (clk),
        .rd      (lbl_rd),
        .rd_data (lbl_rd_data),
        .wr      (lbl_wr)
    );

    gcc_clique_mem u_clique_mem (
        .clk     (clk),
        .rd      (clq_rd),
        .rd_data (clq_rd_data),
        .wr      (clq_wr)
    );

    // Handshake
    assign in_ready  = (state_reg == S_IDLE) || (state_reg == S_UPD && !last_reg);
    assign accept    = in_valid && in_ready;
    assign put_go    = (state_reg == S_PUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Datapath helpers
    assign limit_c    = (max_cliques_reg > CLQ_W'(CLQ_LIMIT)) ? CLQ_W'(CLQ_LIMIT)
                                                               : max_cliques_reg;
    assign cnt_base_c = (clq_rd_data.owner != ord_reg) ? clq_rd_data.size
                                                       : clq_rd_data.count;
    assign cnt_new_c  = (cnt_base_c != '0) ? cnt_base_c - 1'b1 : '0;
    assign size_c     = clq_rd_data.size;
    assign ord_inc_c  = ord_reg + 1'b1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLR;
            max_cliques_reg <= CLQ_W'(CLQ_LIMIT);
            open_reg        <= '0;
            best_reg        <= '0;
            ord_reg         <= '0;
            clr_cnt_reg     <= '0;
            clr_full_reg    <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                max_cliques_reg <= cfg_wdata;
            end
            open_reg      <= open_next;
            best_reg      <= best_next;
            ord_reg       <= ord_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_full_reg  <= clr_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        vtx_reg      <= vtx_next;
        last_reg     <= last_next;
        nb_ok_reg    <= nb_ok_next;
        q_reg        <= q_next;
        q_ok_reg     <= q_ok_next;
        color_reg    <= color_next;
        out_data_reg <= out_data_next;
    end

    // Sequencer: next state, memory requests, result
    always_comb
    begin
        state_next     = state_reg;
        open_next      = open_reg;
        best_next      = best_reg;
        ord_next       = ord_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_full_next  = clr_full_reg;
        vtx_next       = vtx_reg;
        last_next      = last_reg;
        nb_ok_next     = nb_ok_reg;
        q_next         = q_reg;
        q_ok_next      = q_ok_reg;
        color_next     = color_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        lbl_rd         = '0;
        lbl_wr         = '0;
        clq_rd         = '0;
        clq_wr         = '0;

        unique case (state_reg)
            S_CLR:
            begin
                // Sweep: sizes and labels on a full clear, owner tags always
                clq_wr.en_owner   = (32'(clr_cnt_reg) < CLQ_SLOTS);
                clq_wr.en_size    = clr_full_reg && (32'(clr_cnt_reg) < CLQ_SLOTS);
                clq_wr.addr       = CLQ_AW'(clr_cnt_reg);
                clq_wr.data.size  = '0;
                clq_wr.data.owner = TAG_NONE;
                lbl_wr.en         = clr_full_reg && (32'(clr_cnt_reg) < MAX_VERTICES);
                lbl_wr.addr       = LBL_AW'(clr_cnt_reg);
                lbl_wr.data       = '0;
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_CLQ:
            begin
                // Label of the neighbor selects the clique entry
                q_next      = lbl_rd_data;
                q_ok_next   = nb_ok_reg && (lbl_rd_data != '0)
                              && (32'(lbl_rd_data) < CLQ_SLOTS);
                clq_rd.en   = q_ok_next;
                clq_rd.addr = CLQ_AW'(lbl_rd_data);
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                // Scratch count update and candidate tracking
                if (q_ok_reg)
                begin
                    clq_wr.en_owner   = 1'b1;
                    clq_wr.en_count   = 1'b1;
                    clq_wr.addr       = CLQ_AW'(q_reg);
                    clq_wr.data.owner = ord_reg;
                    clq_wr.data.count = cnt_new_c;
                    if (cnt_new_c == '0 && (best_reg == '0 || best_reg > q_reg))
                    begin
                        best_next = q_reg;
                    end
                end
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                // Pick the clique, opening a new one if allowed
                if (best_reg == '0 && open_reg < limit_c)
                begin
                    open_next  = open_reg + 1'b1;
                    color_next = open_reg + 1'b1;
                end
                else
                begin
                    color_next = best_reg;
                end
                clq_rd.en   = 1'b1;
                clq_rd.addr = CLQ_AW'(color_next);
                state_next  = S_PUT;
            end
            S_PUT:
            begin
                // Commit the placement once the output register is free
                if (put_go)
                begin
                    clq_wr.en_size   = 1'b1;
                    clq_wr.addr      = CLQ_AW'(color_reg);
                    clq_wr.data.size = (size_c != SIZE_MAX) ? size_c + 1'b1 : size_c;
                    lbl_wr.en        = (32'(vtx_reg) < MAX_VERTICES);
                    lbl_wr.addr      = LBL_AW'(vtx_reg);
                    lbl_wr.data      = color_reg;
                    best_next        = '0;
                    if (ord_inc_c == TAG_NONE)
                    begin
                        ord_next      = '0;
                        clr_full_next = 1'b0;
                        clr_cnt_next  = '0;
                        state_next    = S_CLR;
                    end
                    else
                    begin
                        ord_next   = ord_inc_c;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Accepted word: start a pass or begin a neighbor lookup
        if (accept)
        begin
            vtx_next   = in_data.vertex;
            last_next  = in_data.last_neighbor;
            nb_ok_next = in_data.has_neighbor && (32'(in_data.neighbor) < MAX_VERTICES);
            if (in_data.req_type == REQ_START)
            begin
                open_next     = '0;
                best_next     = '0;
                ord_next      = '0;
                clr_full_next = 1'b1;
                clr_cnt_next  = '0;
                state_next    = S_CLR;
            end
            else
            begin
                lbl_rd.en   = 1'b1;
                lbl_rd.addr = LBL_AW'(in_data.neighbor);
                state_next  = S_CLQ;
            end
        end

        // Output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (put_go)
        begin
            out_valid_next              = 1'b1;
            out_data_next.placed_vertex = vtx_reg;
            out_data_next.clique        = color_reg;
            out_data_next.position      = (size_c > CLQ_W'(POS_MAX)) ? POS_MAX
                                                                     : POS_W'(size_c);
            out_data_next.cliques_used  = open_reg;
        end
    end

    // Checks
    `GCC_ASSERT_ALWAYS(a_open_bound, open_reg <= CLQ_W'(CLQ_LIMIT), "open cliques above limit")
    `GCC_ASSERT_ALWAYS(a_tag_valid, ord_reg != TAG_NONE, "vertex tag equals no-owner tag")
    `GCC_ASSERT_NEXT(a_put_loads, put_go, out_valid_reg, "placement lost its result")
    `GCC_ASSERT_IMPL(a_color_open, state_reg == S_PUT, color_reg <= open_reg,
                     "clique beyond opened cliques")

endmodule

`default_nettype wire
